/* sv/tlip_pkg.sv */
// ----------------------------------------------------------------------------
// tlip_pkg
// Shared types and constants for the two-level ID to position index.
// ----------------------------------------------------------------------------
package tlip_pkg;

	localparam int ID_W    = 32;
	localparam int CPOS_W  = 4;
	localparam int OPOS_W  = 10;
	localparam int EPOCH_W = 6;

	localparam int CAT_ID_SPACE_DEF = 256;
	localparam int CATALOGS_DEF     = 16;
	localparam int OBJ_ID_SPACE_DEF = 1024;

	typedef enum logic [1:0] {
		ACT_CLEAR   = 2'd0,
		ACT_MAP_CAT = 2'd1,
		ACT_MAP_OBJ = 2'd2,
		ACT_LOOKUP  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_RANGE   = 2'd2
	} status_t;

	// Generation tag stored with every table entry; tag zero never matches.
	typedef logic [EPOCH_W-1:0] epoch_t;

	localparam epoch_t EPOCH_FIRST = epoch_t'(1);
	localparam epoch_t EPOCH_LAST  = '1;

	// Per-item control carried down the pipeline.
	typedef struct packed {
		action_t             act;
		logic                cat_oor;
		logic                obj_oor;
		logic                cpos_oor;
		logic [CPOS_W-1:0]   cpos;
		logic [OPOS_W-1:0]   opos;
	} item_ctl_t;

endpackage

/* sv/tlip_if.sv */
// ----------------------------------------------------------------------------
// tlip_in_if / tlip_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface tlip_in_if import tlip_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [ID_W-1:0]   cat_id;
	logic [ID_W-1:0]   obj_id;
	logic [CPOS_W-1:0] catalog_pos;
	logic [OPOS_W-1:0] object_pos;

	modport source (output valid, action, cat_id, obj_id, catalog_pos, object_pos,
		input ready);
	modport sink (input valid, action, cat_id, obj_id, catalog_pos, object_pos,
		output ready);
endinterface

interface tlip_out_if import tlip_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [CPOS_W-1:0] found_catalog_pos;
	logic [OPOS_W-1:0] found_object_pos;

	modport source (output valid, status, found_catalog_pos, found_object_pos,
		input ready);
	modport sink (input valid, status, found_catalog_pos, found_object_pos,
		output ready);
endinterface

/* sv/two_level_id_to_position_index.sv */
// ----------------------------------------------------------------------------
// two_level_id_to_position_index
// Catalog ID -> catalog position, then (catalog, object ID) -> object position.
// ----------------------------------------------------------------------------
// One command beat is taken per cycle unless a result beat is stuck, a
// clearing pass runs or a wrapping clear sits in the input register. Each beat
// passes through the input register, catalog table read, object table read and
// result register in that order. Entries carry a generation tag instead of
// valid bits, so a clear action finishes in one beat. After reset, and again
// on every 63rd clear, the block runs a clearing pass over every entry of both
// tables during which cmd.ready stays low.
module two_level_id_to_position_index import tlip_pkg::*; #(
	parameter int CAT_ID_SPACE = CAT_ID_SPACE_DEF,
	parameter int CATALOGS     = CATALOGS_DEF,
	parameter int OBJ_ID_SPACE = OBJ_ID_SPACE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	tlip_in_if.sink     cmd,
	tlip_out_if.source  rsp
);

	localparam int CAT_AW    = $clog2(CAT_ID_SPACE);
	localparam int OBJ_IW    = $clog2(OBJ_ID_SPACE);
	localparam int OBJ_DEPTH = CATALOGS * OBJ_ID_SPACE;
	localparam int OBJ_AW    = $clog2(OBJ_DEPTH);
	localparam int SWEEP_LEN = (CAT_ID_SPACE > OBJ_DEPTH) ? CAT_ID_SPACE : OBJ_DEPTH;
	localparam int SW        = $clog2(SWEEP_LEN);

	logic              adv;
	logic              accept;
	logic              wrap_s1;

	logic              v_s1;
	item_ctl_t         ctl_s1;
	logic [CAT_AW-1:0] cat_idx_s1;
	logic [OBJ_IW-1:0] obj_idx_s1;

	epoch_t            epoch_q;
	logic              sweep_q;
	logic [SW-1:0]     sweep_cnt_q;
	logic              cat_sweep_we;
	logic              obj_sweep_we;

	logic              v_s2;
	item_ctl_t         ctl_s2;
	logic [OBJ_IW-1:0] obj_idx_s2;
	epoch_t            epoch_s2;
	logic              cat_hit_s2;
	logic [CPOS_W-1:0] cat_pos_s2;

	logic              v_s3;
	item_ctl_t         ctl_s3;
	logic              cat_hit_s3;
	logic [CPOS_W-1:0] cat_pos_s3;
	logic              obj_hit_s3;
	logic [OPOS_W-1:0] obj_pos_s3;

	status_t           st_d;
	logic [CPOS_W-1:0] fcp_d;
	logic [OPOS_W-1:0] fop_d;

	logic              out_v_q;
	status_t           status_q;
	logic [CPOS_W-1:0] fcp_q;
	logic [OPOS_W-1:0] fop_q;

	// The whole pipeline moves together; hold when a result beat is stuck.
	assign adv     = !out_v_q || rsp.ready;
	assign wrap_s1 = v_s1 && (ctl_s1.act == ACT_CLEAR) && (epoch_q == EPOCH_LAST);
	assign cmd.ready = adv && !sweep_q && !wrap_s1;
	assign accept  = cmd.valid && cmd.ready;

	// Input register, with range checks done on the way in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.act      <= action_t'(cmd.action);
			ctl_s1.cat_oor  <= (cmd.cat_id >= ID_W'(CAT_ID_SPACE));
			ctl_s1.obj_oor  <= (cmd.obj_id >= ID_W'(OBJ_ID_SPACE));
			ctl_s1.cpos_oor <= (int'(cmd.catalog_pos) >= CATALOGS);
			ctl_s1.cpos     <= cmd.catalog_pos;
			ctl_s1.opos     <= cmd.object_pos;
			cat_idx_s1      <= cmd.cat_id[CAT_AW-1:0];
			obj_idx_s1      <= cmd.obj_id[OBJ_IW-1:0];
		end
	end

	// Generation counter and clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= 1'b1;
			sweep_cnt_q <= '0;
			epoch_q     <= EPOCH_FIRST;
		end else begin
			if (sweep_q) begin
				if (sweep_cnt_q == SW'(SWEEP_LEN - 1)) begin
					sweep_q     <= 1'b0;
					sweep_cnt_q <= '0;
				end else begin
					sweep_cnt_q <= sweep_cnt_q + 1'b1;
				end
			end
			if (adv && v_s1 && (ctl_s1.act == ACT_CLEAR)) begin
				if (epoch_q == EPOCH_LAST) begin
					epoch_q     <= EPOCH_FIRST;
					sweep_q     <= 1'b1;
					sweep_cnt_q <= '0;
				end else begin
					epoch_q <= epoch_q + 1'b1;
				end
			end
		end
	end

	assign cat_sweep_we = sweep_q && ({1'b0, sweep_cnt_q} < (SW+1)'(CAT_ID_SPACE));
	assign obj_sweep_we = sweep_q && ({1'b0, sweep_cnt_q} < (SW+1)'(OBJ_DEPTH));

	tlip_cat_stage #(
		.CAT_ID_SPACE (CAT_ID_SPACE),
		.OBJ_ID_SPACE (OBJ_ID_SPACE)
	) u_cat (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.v_s1       (v_s1),
		.ctl_s1     (ctl_s1),
		.cat_idx_s1 (cat_idx_s1),
		.obj_idx_s1 (obj_idx_s1),
		.epoch      (epoch_q),
		.sweep_we   (cat_sweep_we),
		.sweep_addr (sweep_cnt_q[CAT_AW-1:0]),
		.v_s2       (v_s2),
		.ctl_s2     (ctl_s2),
		.obj_idx_s2 (obj_idx_s2),
		.epoch_s2   (epoch_s2),
		.cat_hit_s2 (cat_hit_s2),
		.cat_pos_s2 (cat_pos_s2)
	);

	tlip_obj_stage #(
		.CATALOGS     (CATALOGS),
		.OBJ_ID_SPACE (OBJ_ID_SPACE)
	) u_obj (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.v_s2       (v_s2),
		.ctl_s2     (ctl_s2),
		.obj_idx_s2 (obj_idx_s2),
		.epoch_s2   (epoch_s2),
		.cat_hit_s2 (cat_hit_s2),
		.cat_pos_s2 (cat_pos_s2),
		.sweep_we   (obj_sweep_we),
		.sweep_addr (sweep_cnt_q[OBJ_AW-1:0]),
		.v_s3       (v_s3),
		.ctl_s3     (ctl_s3),
		.cat_hit_s3 (cat_hit_s3),
		.cat_pos_s3 (cat_pos_s3),
		.obj_hit_s3 (obj_hit_s3),
		.obj_pos_s3 (obj_pos_s3)
	);

	// Result decode.
	always_comb begin
		st_d  = ST_OK;
		fcp_d = '0;
		fop_d = '0;
		unique case (ctl_s3.act)
			ACT_CLEAR: begin
				st_d = ST_OK;
			end
			ACT_MAP_CAT: begin
				if (ctl_s3.cat_oor || ctl_s3.cpos_oor) begin
					st_d = ST_RANGE;
				end
			end
			ACT_MAP_OBJ: begin
				if (ctl_s3.obj_oor || ctl_s3.cpos_oor) begin
					st_d = ST_RANGE;
				end
			end
			ACT_LOOKUP: begin
				if (ctl_s3.cat_oor) begin
					st_d = ST_RANGE;
				end else if (!cat_hit_s3 || (int'(cat_pos_s3) >= CATALOGS)) begin
					st_d = ST_MISSING;
				end else if (ctl_s3.obj_oor) begin
					st_d = ST_RANGE;
				end else if (!obj_hit_s3) begin
					st_d = ST_MISSING;
				end else begin
					fcp_d = cat_pos_s3;
					fop_d = obj_pos_s3;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= st_d;
			fcp_q    <= fcp_d;
			fop_q    <= fop_d;
		end
	end

	assign rsp.valid             = out_v_q;
	assign rsp.status            = status_q;
	assign rsp.found_catalog_pos = fcp_q;
	assign rsp.found_object_pos  = fop_q;

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !cmd.ready)
		else $error("command beat taken during clearing pass");

	a_sweep_owns_tables: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_q |-> !v_s1)
		else $error("item in table stage while clearing pass runs");

	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("generation tag reached the reserved value");

	a_result_from_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(v_s3))
		else $error("result beat without an item in the last stage");

endmodule

/* sv/tlip_cat_stage.sv */
// ----------------------------------------------------------------------------
// tlip_cat_stage
// Catalog table access: write on map-catalog, registered read for lookup.
// ----------------------------------------------------------------------------
module tlip_cat_stage import tlip_pkg::*; #(
	parameter int CAT_ID_SPACE = CAT_ID_SPACE_DEF,
	parameter int OBJ_ID_SPACE = OBJ_ID_SPACE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            v_s1,
	input  item_ctl_t                       ctl_s1,
	input  logic [$clog2(CAT_ID_SPACE)-1:0] cat_idx_s1,
	input  logic [$clog2(OBJ_ID_SPACE)-1:0] obj_idx_s1,
	input  epoch_t                          epoch,
	input  logic                            sweep_we,
	input  logic [$clog2(CAT_ID_SPACE)-1:0] sweep_addr,
	output logic                            v_s2,
	output item_ctl_t                       ctl_s2,
	output logic [$clog2(OBJ_ID_SPACE)-1:0] obj_idx_s2,
	output epoch_t                          epoch_s2,
	output logic                            cat_hit_s2,
	output logic [CPOS_W-1:0]               cat_pos_s2
);

	localparam int ENT_W = CPOS_W + EPOCH_W;

	logic [ENT_W-1:0] mem [CAT_ID_SPACE];
	logic [ENT_W-1:0] rd_s2;
	logic             item_we;

	assign item_we = v_s1 && adv && (ctl_s1.act == ACT_MAP_CAT)
		&& !ctl_s1.cat_oor && !ctl_s1.cpos_oor;

	always_ff @(posedge clk) begin
		if (sweep_we) begin
			mem[sweep_addr] <= '0;
		end else if (item_we) begin
			mem[cat_idx_s1] <= {ctl_s1.cpos, epoch};
		end
		if (adv) begin
			rd_s2      <= mem[cat_idx_s1];
			ctl_s2     <= ctl_s1;
			obj_idx_s2 <= obj_idx_s1;
			epoch_s2   <= epoch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	assign cat_pos_s2 = rd_s2[ENT_W-1 -: CPOS_W];
	assign cat_hit_s2 = (rd_s2[EPOCH_W-1:0] == epoch_s2);

endmodule

/* sv/tlip_obj_stage.sv */
// ----------------------------------------------------------------------------
// tlip_obj_stage
// Object table access: slot address, write on map-object, registered read.
// ----------------------------------------------------------------------------
module tlip_obj_stage import tlip_pkg::*; #(
	parameter int CATALOGS     = CATALOGS_DEF,
	parameter int OBJ_ID_SPACE = OBJ_ID_SPACE_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       adv,
	input  logic                                       v_s2,
	input  item_ctl_t                                  ctl_s2,
	input  logic [$clog2(OBJ_ID_SPACE)-1:0]            obj_idx_s2,
	input  epoch_t                                     epoch_s2,
	input  logic                                       cat_hit_s2,
	input  logic [CPOS_W-1:0]                          cat_pos_s2,
	input  logic                                       sweep_we,
	input  logic [$clog2(CATALOGS*OBJ_ID_SPACE)-1:0]   sweep_addr,
	output logic                                       v_s3,
	output item_ctl_t                                  ctl_s3,
	output logic                                       cat_hit_s3,
	output logic [CPOS_W-1:0]                          cat_pos_s3,
	output logic                                       obj_hit_s3,
	output logic [OPOS_W-1:0]                          obj_pos_s3
);

	localparam int OBJ_DEPTH = CATALOGS * OBJ_ID_SPACE;
	localparam int OBJ_AW    = $clog2(OBJ_DEPTH);
	localparam int ENT_W     = OPOS_W + EPOCH_W;

	logic [ENT_W-1:0]  mem [OBJ_DEPTH];
	logic [ENT_W-1:0]  rd_s3;
	epoch_t            epoch_s3;
	logic [CPOS_W-1:0] cp_sel;
	logic [OBJ_AW-1:0] slot;
	logic              item_we;

	// Lookups take the catalog from the table, map-object from the command.
	assign cp_sel  = (ctl_s2.act == ACT_LOOKUP) ? cat_pos_s2 : ctl_s2.cpos;
	assign slot    = OBJ_AW'(OBJ_AW'(cp_sel) * OBJ_AW'(OBJ_ID_SPACE))
		+ OBJ_AW'(obj_idx_s2);
	assign item_we = v_s2 && adv && (ctl_s2.act == ACT_MAP_OBJ)
		&& !ctl_s2.obj_oor && !ctl_s2.cpos_oor;

	always_ff @(posedge clk) begin
		if (sweep_we) begin
			mem[sweep_addr] <= '0;
		end else if (item_we) begin
			mem[slot] <= {ctl_s2.opos, epoch_s2};
		end
		if (adv) begin
			rd_s3      <= mem[slot];
			ctl_s3     <= ctl_s2;
			epoch_s3   <= epoch_s2;
			cat_hit_s3 <= cat_hit_s2;
			cat_pos_s3 <= cat_pos_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	assign obj_pos_s3 = rd_s3[ENT_W-1 -: OPOS_W];
	assign obj_hit_s3 = (rd_s3[EPOCH_W-1:0] == epoch_s3);

endmodule

/* sim/two_level_id_to_position_index_tb.sv */
// ----------------------------------------------------------------------------
// two_level_id_to_position_index_tb
// Self-checking bench for the two-level ID to position index.
// ----------------------------------------------------------------------------
// A directed table covers range errors, table extremes, overwrites and clear.
// Random map/lookup episodes with some noise follow. One run of repeated
// clears pushes the clear count well past the generation wrap. Command and
// result channels idle and stall at random in three of four phases. Every result
// beat is checked against its directed row or a model of both tables, field by field.
module two_level_id_to_position_index_tb;
	import tlip_pkg::*;

	localparam int CAT_SPACE    = CAT_ID_SPACE_DEF;
	localparam int N_CATALOGS   = CATALOGS_DEF;
	localparam int OBJ_SPACE    = OBJ_ID_SPACE_DEF;
	localparam int CAT_IDX_W    = $clog2(CAT_SPACE);
	localparam int CLK_PERIOD   = 10;
	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int PHASE_ITEMS  = 170;
	localparam int N_DIRECTED   = 25;

	typedef struct packed {
		status_t             st;
		logic [CPOS_W-1:0]   cpos;
		logic [OPOS_W-1:0]   opos;
	} index_result_t;

	typedef struct packed {
		action_t             act;
		logic [ID_W-1:0]     cat_id;
		logic [ID_W-1:0]     obj_id;
		logic [CPOS_W-1:0]   cpos;
		logic [OPOS_W-1:0]   opos;
		logic                typed;
		status_t             st;
		logic [CPOS_W-1:0]   fcp;
		logic [OPOS_W-1:0]   fop;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;

	tlip_in_if  cmd ();
	tlip_out_if rsp ();

	two_level_id_to_position_index dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	always begin
		#(CLK_PERIOD / 2) clk = 1'b1;
		#(CLK_PERIOD / 2) clk = 1'b0;
	end

	// Model of both tables
	logic [CPOS_W-1:0]              cat_pos_tbl [CAT_SPACE];
	bit   [CAT_SPACE-1:0]           cat_mapped;
	logic [OPOS_W-1:0]              obj_pos_tbl [N_CATALOGS*OBJ_SPACE];
	bit   [N_CATALOGS*OBJ_SPACE-1:0] obj_mapped;

	index_result_t pending_results [$];
	int            mismatches = 0;
	int            items_sent = 0;
	int            tx_gap_pct = 0;
	int            rx_stall_pct = 0;
	logic          beat_typed;
	index_result_t beat_typed_res;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{ACT_LOOKUP,  32'h0,        32'h0,        4'h0, 10'h000, 1'b1, ST_MISSING, 4'h0, 10'h000},
		'{ACT_LOOKUP,  32'hFFFFFFFF, 32'h0,        4'h0, 10'h000, 1'b1, ST_RANGE,   4'h0, 10'h000},
		'{ACT_MAP_CAT, 32'hFFFFFFFF, 32'h0,        4'h3, 10'h000, 1'b1, ST_RANGE,   4'h0, 10'h000},
		'{ACT_MAP_CAT, 32'd256,      32'h0,        4'h0, 10'h000, 1'b1, ST_RANGE,   4'h0, 10'h000},
		'{ACT_MAP_OBJ, 32'h0,        32'd1024,     4'h0, 10'h000, 1'b1, ST_RANGE,   4'h0, 10'h000},
		'{ACT_MAP_OBJ, 32'h0,        32'hFFFFFFFF, 4'hF, 10'h3FF, 1'b1, ST_RANGE,   4'h0, 10'h000},
		'{ACT_MAP_CAT, 32'h0,        32'h0,        4'h0, 10'h000, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_MAP_CAT, 32'd255,      32'hFFFFFFFF, 4'hF, 10'h3FF, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_MAP_OBJ, 32'h0,        32'h0,        4'h0, 10'h000, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_MAP_OBJ, 32'h0,        32'd1023,     4'hF, 10'h3FF, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_LOOKUP,  32'h0,        32'h0,        4'h0, 10'h000, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_LOOKUP,  32'd255,      32'd1023,     4'h0, 10'h000, 1'b1, ST_OK,      4'hF, 10'h3FF},
		'{ACT_LOOKUP,  32'd255,      32'h0,        4'h0, 10'h000, 1'b1, ST_MISSING, 4'h0, 10'h000},
		'{ACT_LOOKUP,  32'h0,        32'd1024,     4'h0, 10'h000, 1'b1, ST_RANGE,   4'h0, 10'h000},
		'{ACT_LOOKUP,  32'h1,        32'hFFFFFFFF, 4'h0, 10'h000, 1'b1, ST_MISSING, 4'h0, 10'h000},
		'{ACT_MAP_CAT, 32'h0,        32'h0,        4'hF, 10'h000, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_LOOKUP,  32'h0,        32'd1023,     4'h0, 10'h000, 1'b0, ST_OK,      4'h0, 10'h000},
		'{ACT_MAP_OBJ, 32'h0,        32'd1023,     4'hF, 10'h2AA, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_LOOKUP,  32'd255,      32'd1023,     4'h0, 10'h000, 1'b0, ST_OK,      4'h0, 10'h000},
		'{ACT_MAP_CAT, 32'hAA,       32'h0,        4'h5, 10'h000, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_MAP_OBJ, 32'h0,        32'h155,      4'h5, 10'h155, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_LOOKUP,  32'hAA,       32'h155,      4'h0, 10'h000, 1'b0, ST_OK,      4'h0, 10'h000},
		'{ACT_LOOKUP,  32'h100,      32'h0,        4'h0, 10'h000, 1'b1, ST_RANGE,   4'h0, 10'h000},
		'{ACT_CLEAR,   32'hFFFFFFFF, 32'hFFFFFFFF, 4'hF, 10'h3FF, 1'b1, ST_OK,      4'h0, 10'h000},
		'{ACT_LOOKUP,  32'hAA,       32'h155,      4'h0, 10'h000, 1'b1, ST_MISSING, 4'h0, 10'h000}
	};

	function automatic index_result_t index_outcome(input action_t act,
		input logic [ID_W-1:0] cid, input logic [ID_W-1:0] oid,
		input logic [CPOS_W-1:0] cp, input logic [OPOS_W-1:0] op);
		index_result_t r;
		int            slot;
		logic [CPOS_W-1:0] owner;
		r = '{ST_OK, '0, '0};
		case (act)
			ACT_CLEAR: begin
				cat_mapped = '0;
				obj_mapped = '0;
			end
			ACT_MAP_CAT: begin
				if (cid >= CAT_SPACE || cp >= N_CATALOGS) begin
					r.st = ST_RANGE;
				end else begin
					cat_pos_tbl[cid[CAT_IDX_W-1:0]] = cp;
					cat_mapped[cid[CAT_IDX_W-1:0]]  = 1'b1;
				end
			end
			ACT_MAP_OBJ: begin
				if (oid >= OBJ_SPACE || cp >= N_CATALOGS) begin
					r.st = ST_RANGE;
				end else begin
					slot = int'(cp) * OBJ_SPACE + int'(oid);
					obj_pos_tbl[slot] = op;
					obj_mapped[slot]  = 1'b1;
				end
			end
			default: begin
				// catalog stage first: an unmapped catalog hides a bad object ID
				if (cid >= CAT_SPACE) begin
					r.st = ST_RANGE;
				end else if (!cat_mapped[cid[CAT_IDX_W-1:0]]) begin
					r.st = ST_MISSING;
				end else if (oid >= OBJ_SPACE) begin
					r.st = ST_RANGE;
				end else begin
					owner = cat_pos_tbl[cid[CAT_IDX_W-1:0]];
					slot  = int'(owner) * OBJ_SPACE + int'(oid);
					if (!obj_mapped[slot])
						r.st = ST_MISSING;
					else
						r = '{ST_OK, owner, obj_pos_tbl[slot]};
				end
			end
		endcase
		return r;
	endfunction

	task automatic note_failure(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// Results are popped before the same-edge command beat is pushed.
	always @(posedge clk) begin : watch
		index_result_t want;
		index_result_t got;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = '{status_t'(rsp.status), rsp.found_catalog_pos, rsp.found_object_pos};
				if (pending_results.size() == 0) begin
					note_failure($sformatf("result beat with none expected: st %0d cp %0d op %0d",
						got.st, got.cpos, got.opos));
				end else begin
					want = pending_results.pop_front();
					if (got.st !== want.st || got.cpos !== want.cpos || got.opos !== want.opos)
						note_failure($sformatf("st %0d/%0d cp %0d/%0d op %0d/%0d (exp/act)",
							want.st, got.st, want.cpos, got.cpos, want.opos, got.opos));
				end
			end
			if (cmd.valid && cmd.ready) begin
				want = index_outcome(action_t'(cmd.action), cmd.cat_id, cmd.obj_id,
					cmd.catalog_pos, cmd.object_pos);
				if (beat_typed)
					want = beat_typed_res;
				pending_results.push_back(want);
			end
		end
	end

	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(1, 100) > rx_stall_pct);
	end

	task automatic send_beat(input action_t act, input logic [ID_W-1:0] cid,
		input logic [ID_W-1:0] oid, input logic [CPOS_W-1:0] cp,
		input logic [OPOS_W-1:0] op, input logic typed = 1'b0,
		input index_result_t typed_res = '0);
		while ($urandom_range(1, 100) <= tx_gap_pct) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.action      <= act;
		cmd.cat_id      <= cid;
		cmd.obj_id      <= oid;
		cmd.catalog_pos <= cp;
		cmd.object_pos  <= op;
		beat_typed      <= typed;
		beat_typed_res  <= typed_res;
		do @(posedge clk); while (!cmd.ready);
		items_sent++;
		@(negedge clk);
	endtask

	function automatic logic [ID_W-1:0] pick_cat_id();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd255;
			2: return 32'h55;
			3: return 32'hAA;
			4: return 32'd128;
			default: return 32'($urandom_range(0, CAT_SPACE - 1));
		endcase
	endfunction

	function automatic logic [ID_W-1:0] pick_obj_id();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'd1023;
			2: return 32'h155;
			3: return 32'h2AA;
			4: return 32'd512;
			default: return 32'($urandom_range(0, OBJ_SPACE - 1));
		endcase
	endfunction

	function automatic logic [CPOS_W-1:0] pick_cpos();
		case ($urandom_range(0, 4))
			0: return 4'h0;
			1: return 4'hF;
			2: return 4'h5;
			default: return 4'($urandom);
		endcase
	endfunction

	// Half the picks are out of range (any 32-bit value, or from the space up to twice it).
	function automatic logic [ID_W-1:0] wild_id(input int space);
		case ($urandom_range(0, 3))
			0: return 32'($urandom);
			1: return 32'($urandom_range(space, 2 * space));
			default: return 32'($urandom_range(0, space - 1));
		endcase
	endfunction

	task automatic random_episode();
		logic [ID_W-1:0]   cid;
		logic [ID_W-1:0]   oids [3];
		logic [CPOS_W-1:0] cp;
		int                nobj;
		int                roll;
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			send_beat(ACT_CLEAR, $urandom, $urandom, 4'($urandom), 10'($urandom));
		end else if (roll < 25) begin
			send_beat(action_t'($urandom_range(0, 3)), wild_id(CAT_SPACE), wild_id(OBJ_SPACE),
				4'($urandom), 10'($urandom));
		end else begin
			cid = pick_cat_id();
			cp  = pick_cpos();
			// skip the catalog map now and then to look up through an older mapping
			if ($urandom_range(0, 3) != 0)
				send_beat(ACT_MAP_CAT, cid, $urandom, cp, 10'($urandom));
			nobj = $urandom_range(1, 3);
			for (int i = 0; i < nobj; i++) begin
				oids[i] = pick_obj_id();
				send_beat(ACT_MAP_OBJ, $urandom, oids[i], cp, 10'($urandom));
			end
			repeat ($urandom_range(1, 3)) begin
				send_beat(ACT_LOOKUP,
					($urandom_range(0, 3) == 0) ? pick_cat_id() : cid,
					($urandom_range(0, 3) == 0) ? pick_obj_id() : oids[$urandom_range(0, nobj - 1)],
					4'($urandom), 10'($urandom));
			end
		end
	endtask

	// Run the clear count well past one generation wrap; the pair mapped
	// before the clears must never come back.
	task automatic clear_storm();
		send_beat(ACT_MAP_CAT, 32'h33, $urandom, 4'h7, 10'($urandom));
		send_beat(ACT_MAP_OBJ, $urandom, 32'h77, 4'h7, 10'h1C3);
		send_beat(ACT_LOOKUP, 32'h33, 32'h77, 4'($urandom), 10'($urandom));
		repeat (66) begin
			send_beat(ACT_CLEAR, $urandom, $urandom, 4'($urandom), 10'($urandom));
			send_beat(ACT_LOOKUP, 32'h33, 32'h77, 4'($urandom), 10'($urandom));
		end
	endtask

	initial begin : stimulus
		index_result_t typed_res;
		int            phase_start;
		arst_n          = 1'b0;
		cmd.valid       = 1'b0;
		cmd.action      = ACT_CLEAR;
		cmd.cat_id      = '0;
		cmd.obj_id      = '0;
		cmd.catalog_pos = '0;
		cmd.object_pos  = '0;
		rsp.ready       = 1'b0;
		beat_typed      = 1'b0;
		beat_typed_res  = '0;
		cat_mapped      = '0;
		obj_mapped      = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			typed_res = '{directed_rows[i].st, directed_rows[i].fcp, directed_rows[i].fop};
			send_beat(directed_rows[i].act, directed_rows[i].cat_id, directed_rows[i].obj_id,
				directed_rows[i].cpos, directed_rows[i].opos, directed_rows[i].typed, typed_res);
		end

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_gap_pct = 53; rx_stall_pct = 0;  end
				2: begin tx_gap_pct = 0;  rx_stall_pct = 53; end
				default: begin tx_gap_pct = 23; rx_stall_pct = 23; end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS)
				random_episode();
			if (ph == 1)
				clear_storm();
		end

		cmd.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#(CLK_PERIOD * LIMIT_CYCLES);
		$display("FAILURE");
		$finish;
	end

endmodule
